// File: rtl/spc_pkg.sv
// Shared types and constants for the shortest path count block.
package spc_pkg;

	localparam int MaxNodes = 512;
	localparam int MaxEdges = 1024;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EDGE = 2'd1;
	localparam logic [1:0] OP_SOLVE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_SOURCE = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	localparam int DistW = 20;
	localparam int TeamW = 20;
	localparam int CountW = 32;

	// per-node working entry
	typedef struct packed {
		logic reached;
		logic visited;
		logic [DistW-1:0] distance;
		logic [TeamW-1:0] teams;
		logic [CountW-1:0] count;
	} node_entry_t;

endpackage

// File: rtl/spc_node_mem.sv
// Node working memory: one write port, one read port, registered read data.
module spc_node_mem #(
	parameter int AW = 9
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  spc_pkg::node_entry_t    wdata,
	input  logic [AW-1:0]           raddr,
	output spc_pkg::node_entry_t    rdata
);
	spc_pkg::node_entry_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/spc_edge_mem.sv
// Edge list memory: endpoints and length per entry.
module spc_edge_mem #(
	parameter int NW = 9,
	parameter int EW = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [EW-1:0]       waddr,
	input  logic [2*NW+9:0]     wdata,
	input  logic [EW-1:0]       raddr,
	output logic [2*NW+9:0]     rdata
);
	logic [2*NW+9:0] mem [2**EW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/shortest_path_count_max_weight.sv
// Load and add edge transactions are taken one per cycle while not busy, no result.
// Solve: busy until the result is read out, then done for one cycle; a new
// transaction may be accepted in the done cycle. The receiver cannot stall.
// Reset clears registers, edge count and control; memories are not cleared.
module shortest_path_count_max_weight #(
	parameter int MAX_NODES = spc_pkg::MaxNodes,
	parameter int MAX_EDGES = spc_pkg::MaxEdges
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [8:0]  first_node,
	input  logic [8:0]  second_node,
	input  logic [9:0]  edge_length,
	input  logic [9:0]  team_count,
	output logic        done,
	output logic [31:0] path_count,
	output logic [18:0] max_teams,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	localparam int NA = $clog2(MAX_NODES);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NC = $clog2(MAX_NODES + 1);
	localparam int EC = $clog2(MAX_EDGES + 1);
	localparam int TW = spc_pkg::TeamW;
	localparam int DW = spc_pkg::DistW;
	localparam int CW = spc_pkg::CountW;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_INIT   = 10'b0000000010,
		S_INITW  = 10'b0000000100,
		S_SCAN   = 10'b0000001000,
		S_PICK   = 10'b0000010000,
		S_EREAD  = 10'b0000100000,
		S_ECHK   = 10'b0001000000,
		S_VREAD  = 10'b0010000000,
		S_RELAX  = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [9:0] node_count_q;
	logic [8:0] source_q, target_q;
	logic [EC-1:0] edge_total_q;
	logic [NC-1:0] n_eff;

	// team memory
	logic [9:0] team_mem [MAX_NODES];
	logic [9:0] team_rd;
	logic [NA-1:0] team_raddr;

	// scan bookkeeping
	logic [NC-1:0] idx_q;
	logic [NC-1:0] idx_d1_q;
	logic rd_valid_q;
	logic found_q;
	logic [NA-1:0] best_q;
	logic [DW-1:0] best_dist_q;
	spc_pkg::node_entry_t u_q;
	logic [NA-1:0] u_idx_q;
	logic [EC-1:0] eidx_q;
	logic [NA-1:0] v_q;
	logic [9:0] len_q;

	// memories
	logic nm_we;
	logic [NA-1:0] nm_waddr, nm_raddr;
	spc_pkg::node_entry_t nm_wdata, nm_rdata;
	logic em_we;
	logic [2*9+9:0] em_wdata, em_rdata;
	logic [EA-1:0] em_raddr;

	spc_node_mem #(.AW(NA)) u_node (
		.clk, .we(nm_we), .waddr(nm_waddr), .wdata(nm_wdata),
		.raddr(nm_raddr), .rdata(nm_rdata)
	);
	spc_edge_mem #(.NW(9), .EW(EA)) u_edge (
		.clk, .we(em_we), .waddr(edge_total_q[EA-1:0]), .wdata(em_wdata),
		.raddr(em_raddr), .rdata(em_rdata)
	);

	always_comb begin
		if (node_count_q == 10'd0) begin
			n_eff = NC'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_eff = NC'(MAX_NODES);
		end else begin
			n_eff = NC'(node_count_q);
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 10'd1;
			source_q <= '0;
			target_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spc_pkg::REG_NODE_COUNT: node_count_q <= cfg_data;
				spc_pkg::REG_SOURCE:     source_q <= cfg_data[8:0];
				spc_pkg::REG_TARGET:     target_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// team store write and read
	always_ff @(posedge clk) begin
		if (accept && operation == spc_pkg::OP_LOAD && 32'(first_node) < MAX_NODES) begin
			team_mem[NA'(first_node)] <= team_count;
		end
		team_rd <= team_mem[team_raddr];
	end

	// edge append
	logic full;
	assign full = (32'(edge_total_q) >= MAX_EDGES);
	assign em_we = accept && operation == spc_pkg::OP_EDGE && !full;
	assign em_wdata = {first_node, second_node,
		(edge_length == 10'd0) ? 10'd1 : edge_length};

	// edge fields from memory
	logic [8:0] ea, eb;
	logic [9:0] elen;
	assign ea = em_rdata[27:19];
	assign eb = em_rdata[18:10];
	assign elen = em_rdata[9:0];

	// relaxation candidates
	logic [DW-1:0] nd;
	logic [TW-1:0] nt;
	logic [CW:0] csum;
	assign nd = u_q.distance + DW'(len_q);
	assign nt = u_q.teams + TW'(team_rd);
	assign csum = {1'b0, nm_rdata.count} + {1'b0, u_q.count};

	// address and write control
	always_comb begin
		nm_we = 1'b0;
		nm_waddr = idx_d1_q[NA-1:0];
		nm_wdata = '0;
		nm_raddr = idx_q[NA-1:0];
		team_raddr = idx_q[NA-1:0];
		em_raddr = eidx_q[EA-1:0];
		case (state_q)
			S_INITW: begin
				nm_we = 1'b1;
				nm_wdata.reached = (idx_d1_q[NA-1:0] == NA'(source_q)) &&
					(NC'(source_q) < n_eff);
				nm_wdata.count = nm_wdata.reached ? CW'(1) : '0;
				nm_wdata.teams = TW'(team_rd);
			end
			S_PICK: begin
				nm_raddr = best_q;
			end
			S_EREAD: begin
				// mark the picked node settled on its first edge pass
				nm_we = (eidx_q == '0);
				nm_waddr = u_idx_q;
				nm_wdata = nm_rdata;
				nm_wdata.visited = 1'b1;
			end
			S_ECHK: begin
				nm_raddr = (NA'(ea) == u_idx_q) ? NA'(eb) : NA'(ea);
				team_raddr = nm_raddr;
			end
			S_RELAX: begin
				nm_waddr = v_q;
				nm_wdata = nm_rdata;
				if (!nm_rdata.visited) begin
					if (!nm_rdata.reached || nd < nm_rdata.distance) begin
						nm_we = 1'b1;
						nm_wdata.reached = 1'b1;
						nm_wdata.distance = nd;
						nm_wdata.teams = nt;
						nm_wdata.count = u_q.count;
					end else if (nd == nm_rdata.distance) begin
						nm_we = 1'b1;
						nm_wdata.count = csum[CW] ? '1 : csum[CW-1:0];
						if (nt > nm_rdata.teams) begin
							nm_wdata.teams = nt;
						end
					end
				end
			end
			S_OUT, S_VREAD: begin
				nm_raddr = NA'(target_q);
			end
			default: ;
		endcase
	end

	// solve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			edge_total_q <= '0;
			idx_q <= '0;
			idx_d1_q <= '0;
			rd_valid_q <= 1'b0;
			found_q <= 1'b0;
			best_q <= '0;
			best_dist_q <= '0;
			u_q <= '0;
			u_idx_q <= '0;
			eidx_q <= '0;
			v_q <= '0;
			len_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (state_q == S_VREAD);
			if (em_we) begin
				edge_total_q <= edge_total_q + EC'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && operation == spc_pkg::OP_SOLVE) begin
						state_q <= S_INIT;
						idx_q <= '0;
					end
				end
				S_INIT: begin
					idx_d1_q <= idx_q;
					idx_q <= idx_q + NC'(1);
					state_q <= S_INITW;
				end
				S_INITW: begin
					if (idx_q == n_eff) begin
						state_q <= S_SCAN;
						idx_q <= '0;
						rd_valid_q <= 1'b0;
						found_q <= 1'b0;
					end else begin
						state_q <= S_INIT;
					end
				end
				S_SCAN: begin
					// one read per cycle, compare the previous read
					rd_valid_q <= (idx_q < n_eff);
					idx_d1_q <= idx_q;
					if (idx_q < n_eff) begin
						idx_q <= idx_q + NC'(1);
					end
					if (rd_valid_q && nm_rdata.reached && !nm_rdata.visited &&
						(!found_q || nm_rdata.distance < best_dist_q)) begin
						found_q <= 1'b1;
						best_q <= idx_d1_q[NA-1:0];
						best_dist_q <= nm_rdata.distance;
					end
					if (!rd_valid_q && idx_q == n_eff) begin
						if (found_q) begin
							state_q <= S_PICK;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_PICK: begin
					u_idx_q <= best_q;
					eidx_q <= '0;
					state_q <= S_EREAD;
				end
				S_EREAD: begin
					if (eidx_q == '0) begin
						u_q <= nm_rdata;
					end
					if (eidx_q == edge_total_q) begin
						state_q <= S_SCAN;
						idx_q <= '0;
						rd_valid_q <= 1'b0;
						found_q <= 1'b0;
					end else begin
						state_q <= S_ECHK;
					end
				end
				S_ECHK: begin
					eidx_q <= eidx_q + EC'(1);
					v_q <= (NA'(ea) == u_idx_q) ? NA'(eb) : NA'(ea);
					len_q <= elen;
					if (NC'(ea) < n_eff && NC'(eb) < n_eff &&
						(NA'(ea) == u_idx_q || NA'(eb) == u_idx_q)) begin
						state_q <= S_RELAX;
					end else begin
						state_q <= S_EREAD;
					end
				end
				S_RELAX: begin
					state_q <= S_EREAD;
				end
				S_OUT: begin
					state_q <= S_VREAD;
				end
				S_VREAD: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result fields, valid with done
	logic tgt_ok;
	assign tgt_ok = (NC'(target_q) < n_eff);
	assign path_count = tgt_ok ? nm_rdata.count : '0;
	assign max_teams = tgt_ok ? nm_rdata.teams[18:0] : '0;
endmodule

// File: rtl/spc_checker.sv
// Port-level checker for the shortest path count block, bound to the top level.
module spc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic       done
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without solve");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during result");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation != spc_pkg::OP_SOLVE) |=> !busy)
		else $error("busy after non-solve transaction");
endmodule

bind shortest_path_count_max_weight spc_checker u_spc_checker (
	.clk, .arst_n, .start, .busy, .operation, .done
);
